// ===== src/bba_pkg.sv =====
// shared constants, types and tree geometry functions of the buddy block allocator
`default_nettype none

package bba_pkg;

  // sizes of the managed region and of the smallest block
  localparam int unsigned MEM_SIZE  = 1024;
  localparam int unsigned MIN_BLOCK = 16;

  // fixed field widths
  localparam int unsigned REQ_W   = 11;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned OFF_W   = 10;

  // tree geometry
  localparam int unsigned LOG_MEM  = $clog2(MEM_SIZE);
  localparam int unsigned NODE_W   = $clog2(MEM_SIZE / MIN_BLOCK) + 1;
  localparam int unsigned NODE_CNT = (2 ** NODE_W) - 1;
  localparam int unsigned LVL_W    = (NODE_W > 1) ? $clog2(NODE_W) : 1;
  localparam int unsigned SIZE_W   = LOG_MEM + 1;
  localparam int unsigned CMP_W    = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
  localparam int unsigned ENTRY_W  = 2 + LABEL_W;

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_CNT);

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_FREE    = 2'd1,
    ST_DIVIDED = 2'd2,
    ST_ALLOC   = 2'd3
  } node_state_e;

  typedef enum logic [1:0] {
    ADDR_NODE,
    ADDR_LEFT,
    ADDR_RIGHT
  } addr_sel_e;

  typedef enum logic [2:0] {
    NODE_HOLD,
    NODE_ROOT,
    NODE_LEFT,
    NODE_NEXT,
    NODE_PARENT,
    NODE_INC,
    NODE_FOUND
  } node_op_e;

  // controller to datapath
  typedef struct packed {
    logic        in_load;
    logic        rd_en;
    logic        wr_en;
    addr_sel_e   addr_sel;
    node_state_e wr_state;
    node_op_e    node_op;
    logic        res_load;
    logic        res_ok;
    logic        out_push;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    node_state_e rd_state;
    logic        rd_pend;
    logic        rd_match;
    logic        rd_last;
    logic        fits;
    logic        split_ok;
    logic        next_none;
    logic        node_root;
    logic        out_free;
  } bba_sts_t;

  // depth of a heap node (position of its top bit)
  function automatic logic [LVL_W-1:0] node_level(input logic [NODE_W-1:0] node);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (node[i]) lvl = LVL_W'(i);
    end
    return lvl;
  endfunction

  // block size covered by a node
  function automatic logic [SIZE_W-1:0] node_size(input logic [NODE_W-1:0] node);
    return SIZE_W'(MEM_SIZE) >> node_level(node);
  endfunction

  // start offset of a node's block
  function automatic logic [LOG_MEM-1:0] node_offset(input logic [NODE_W-1:0] node);
    logic [LVL_W-1:0]          lvl;
    logic [NODE_W-1:0]         rel;
    logic [LOG_MEM+NODE_W-1:0] wide;
    lvl  = node_level(node);
    rel  = node & ~(ROOT_NODE << lvl);
    wide = (LOG_MEM + NODE_W)'(rel) << (LOG_MEM - int'(lvl));
    return wide[LOG_MEM-1:0];
  endfunction

  // preorder successor when the subtree of node is skipped, zero when done
  function automatic logic [NODE_W-1:0] next_preorder(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] n;
    n = node;
    for (int i = 0; i < NODE_W; i++) begin
      if ((n > ROOT_NODE) && n[0]) n = n >> 1;
    end
    if (n <= ROOT_NODE) return '0;
    return n + NODE_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/bba_ifs.sv =====
// request and result channel interfaces of the buddy block allocator
`default_nettype none

interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bba_pkg::REQ_W-1:0]   request_size;
  logic [bba_pkg::LABEL_W-1:0] label;

  modport source (output valid, output mode, output request_size, output label,
                  input ready);
  modport sink (input valid, input mode, input request_size, input label,
                output ready);
endinterface

interface bba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [bba_pkg::OFF_W-1:0] block_offset;

  modport source (output valid, output ok, output block_offset, input ready);
  modport sink (input valid, input ok, input block_offset, output ready);
endinterface

`default_nettype wire

// ===== src/bba_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/bba_ctrl.sv =====
// sequencer for tree walk, split, search and merge of the buddy block allocator
`default_nettype none

module bba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_mode_i,
  output logic                   in_ready_o,
  input  wire bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t      cmd_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_SL,
    S_A_SR,
    S_F_SC,
    S_F_WR,
    S_M_RP,
    S_M_RL,
    S_M_RR,
    S_M_CK,
    S_M_WL,
    S_M_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          cmd_o.node_op = NODE_ROOT;
          state_d       = (in_mode_i == MODE_FREE) ? S_F_SC : S_A_RD;
        end
      end
      // allocate: read the current node
      S_A_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_A_EV;
      end
      // allocate: descend, split, take or skip
      S_A_EV: begin
        priority if (sts_i.rd_state == ST_DIVIDED) begin
          cmd_o.node_op = NODE_LEFT;
          state_d       = S_A_RD;
        end else if (sts_i.rd_state == ST_FREE && sts_i.fits && sts_i.split_ok) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_state = ST_DIVIDED;
          state_d        = S_A_SL;
        end else if (sts_i.rd_state == ST_FREE && sts_i.fits) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_state = ST_ALLOC;
          cmd_o.res_load = 1'b1;
          cmd_o.res_ok   = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.next_none) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.node_op = NODE_NEXT;
          state_d       = S_A_RD;
        end
      end
      S_A_SL: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = ADDR_LEFT;
        cmd_o.wr_state = ST_FREE;
        state_d        = S_A_SR;
      end
      S_A_SR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = ADDR_RIGHT;
        cmd_o.wr_state = ST_FREE;
        cmd_o.node_op  = NODE_LEFT;
        state_d        = S_A_RD;
      end
      // free: breadth-first scan, one read issued per cycle
      S_F_SC: begin
        priority if (sts_i.rd_pend && sts_i.rd_match) begin
          cmd_o.node_op = NODE_FOUND;
          state_d       = S_F_WR;
        end else if (sts_i.rd_pend && sts_i.rd_last) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.node_op = NODE_INC;
        end
      end
      S_F_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_state = ST_FREE;
        cmd_o.res_load = 1'b1;
        cmd_o.res_ok   = 1'b1;
        if (sts_i.node_root) begin
          state_d = S_DONE;
        end else begin
          cmd_o.node_op = NODE_PARENT;
          state_d       = S_M_RP;
        end
      end
      // merge: check parent and both children
      S_M_RP: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_M_RL;
      end
      S_M_RL: begin
        if (sts_i.rd_state != ST_DIVIDED) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_LEFT;
          state_d        = S_M_RR;
        end
      end
      S_M_RR: begin
        if (sts_i.rd_state != ST_FREE) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_RIGHT;
          state_d        = S_M_CK;
        end
      end
      S_M_CK: begin
        if (sts_i.rd_state != ST_FREE) begin
          state_d = S_DONE;
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_state = ST_FREE;
          state_d        = S_M_WL;
        end
      end
      S_M_WL: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = ADDR_LEFT;
        cmd_o.wr_state = ST_UNUSED;
        state_d        = S_M_WR;
      end
      S_M_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = ADDR_RIGHT;
        cmd_o.wr_state = ST_UNUSED;
        if (sts_i.node_root) begin
          state_d = S_DONE;
        end else begin
          cmd_o.node_op = NODE_PARENT;
          state_d       = S_M_RP;
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bba_dp.sv =====
// node store, node pointer, geometry and result registers of the buddy block allocator
`default_nettype none

module bba_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bba_pkg::bba_cmd_t           cmd_i,
  output bba_pkg::bba_sts_t                sts_o,
  input  wire logic [bba_pkg::REQ_W-1:0]   request_size_i,
  input  wire logic [bba_pkg::LABEL_W-1:0] label_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_ok_o,
  output logic [bba_pkg::OFF_W-1:0]        out_offset_o
);
  import bba_pkg::*;

  localparam int unsigned DEPTH = 2 ** NODE_W;

  logic [REQ_W-1:0]   req_q;
  logic [LABEL_W-1:0] label_q;
  logic [NODE_W-1:0]  node_q, node_d;
  logic [NODE_W-1:0]  rd_node_q;
  logic               rd_pend_q;
  logic               rd_vld_q;
  logic [DEPTH-1:0]   vld_q;
  logic               res_ok_q;
  logic [OFF_W-1:0]   res_off_q;
  logic               out_valid_q;
  logic               out_ok_q;
  logic [OFF_W-1:0]   out_off_q;

  logic [NODE_W-1:0]  addr;
  logic [NODE_W-1:0]  next_pre;
  logic [ENTRY_W-1:0] rdata;
  node_state_e        rd_state;
  logic [SIZE_W-1:0]  size;
  logic [CMP_W-1:0]   size_c, half_c, req_c, min_c;

  // node store address
  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_NODE:  addr = node_q;
      ADDR_LEFT:  addr = {node_q[NODE_W-2:0], 1'b0};
      ADDR_RIGHT: addr = {node_q[NODE_W-2:0], 1'b1};
      default:    addr = node_q;
    endcase
  end

  // node state and label store
  bba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (addr),
    .wdata_i ({cmd_i.wr_state, label_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // a never-written node reads as its reset state
  always_comb begin
    if (rd_vld_q) begin
      rd_state = node_state_e'(rdata[ENTRY_W-1 -: 2]);
    end else if (rd_node_q == ROOT_NODE) begin
      rd_state = ST_FREE;
    end else begin
      rd_state = ST_UNUSED;
    end
  end

  // written flags and read bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) vld_q[addr] <= 1'b1;
      rd_pend_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_node_q <= addr;
      rd_vld_q  <= vld_q[addr];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      req_q   <= request_size_i;
      label_q <= label_i;
    end
  end

  // node pointer
  assign next_pre = next_preorder(node_q);

  always_comb begin
    unique case (cmd_i.node_op)
      NODE_HOLD:   node_d = node_q;
      NODE_ROOT:   node_d = ROOT_NODE;
      NODE_LEFT:   node_d = {node_q[NODE_W-2:0], 1'b0};
      NODE_NEXT:   node_d = next_pre;
      NODE_PARENT: node_d = node_q >> 1;
      NODE_INC:    node_d = node_q + NODE_W'(1);
      NODE_FOUND:  node_d = rd_node_q;
      default:     node_d = node_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= ROOT_NODE;
    end else begin
      node_q <= node_d;
    end
  end

  // size tests for the current node
  assign size   = node_size(node_q);
  assign size_c = CMP_W'(size);
  assign half_c = CMP_W'(size >> 1);
  assign req_c  = CMP_W'(req_q);
  assign min_c  = CMP_W'(MIN_BLOCK);

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_ok_q  <= cmd_i.res_ok;
      res_off_q <= cmd_i.res_ok ? OFF_W'(node_offset(node_q)) : '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      out_ok_q  <= res_ok_q;
      out_off_q <= res_off_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = out_ok_q;
  assign out_offset_o = out_off_q;

  // status
  always_comb begin
    sts_o           = '0;
    sts_o.rd_state  = rd_state;
    sts_o.rd_pend   = rd_pend_q;
    sts_o.rd_match  = (rd_state == ST_ALLOC) && (rdata[LABEL_W-1:0] == label_q);
    sts_o.rd_last   = (rd_node_q == LAST_NODE);
    sts_o.fits      = (size_c >= req_c);
    sts_o.split_ok  = (half_c >= req_c) && (half_c >= min_c);
    sts_o.next_none = (next_pre == '0);
    sts_o.node_root = (node_q == ROOT_NODE);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ===== src/buddy_block_allocator.sv =====
// top level of the buddy block allocator
//
//  channel   dir  handshake     payload
//  req_chan  in   valid/ready   mode, request_size, label
//  rsp_chan  out  valid/ready   ok, block_offset
//
// one request at a time, accepted, worked, then handed off; allocate reads
// each node visited in the depth-first walk and writes both halves on each split,
// free reads nodes in breadth-first order, then frees the found node and checks
// and rewrites each merged level; the node store's shared address sets the pace.
// no clearing pass after reset: per-node written flags make the root read free.
// a waiting result sits in the output register while the next request is worked.
`default_nettype none

module buddy_block_allocator (
  input wire logic clk_i,
  input wire logic rst_ni,
  bba_req_if.sink  req_chan,
  bba_rsp_if.source rsp_chan
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  // controller
  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_chan.valid),
    .in_mode_i  (req_chan.mode),
    .in_ready_o (req_chan.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  bba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .request_size_i (req_chan.request_size),
    .label_i        (req_chan.label),
    .out_ready_i    (rsp_chan.ready),
    .out_valid_o    (rsp_chan.valid),
    .out_ok_o       (rsp_chan.ok),
    .out_offset_o   (rsp_chan.block_offset)
  );

endmodule

`default_nettype wire

// ===== src/bba_checker.sv =====
// port-level assertions of the buddy block allocator and their binding
`default_nettype none

module bba_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      req_valid_i,
  input wire logic                      req_ready_i,
  input wire logic                      rsp_valid_i,
  input wire logic                      rsp_ready_i,
  input wire logic                      rsp_ok_i,
  input wire logic [bba_pkg::OFF_W-1:0] rsp_block_offset_i
);

  logic [1:0] pend_q;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (req_acc && !rsp_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (rsp_acc && !req_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // a result only answers a request taken earlier
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pend_q != 2'd0))
    else $error("result without an open request");

  // one request at work and one result waiting blocks further requests
  a_no_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd2) |-> !req_ready_i)
    else $error("request taken while two are open");

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> ($stable(rsp_ok_i) && $stable(rsp_block_offset_i)))
    else $error("result payload changed while stalled");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_chan.valid),
  .req_ready_i        (req_chan.ready),
  .rsp_valid_i        (rsp_chan.valid),
  .rsp_ready_i        (rsp_chan.ready),
  .rsp_ok_i           (rsp_chan.ok),
  .rsp_block_offset_i (rsp_chan.block_offset)
);

`default_nettype wire

// ===== sim/bba_grant_checker.sv =====
// checker for the buddy block allocator: tracks the block tree and compares every result
`default_nettype none

module bba_grant_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bba_req_if          req_chan,
  bba_rsp_if          rsp_chan,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] offset;
  } grant_t;

  // shadow copy of the block tree, heap order, root is node 1
  node_state_e        blk_state [1:NODE_CNT];
  logic [LABEL_W-1:0] blk_owner [1:NODE_CNT];

  grant_t      grants_due [$];
  int unsigned mismatches;

  // depth of a heap node below the root
  function automatic int unsigned tree_depth(input int unsigned n);
    int unsigned d;
    d = 0;
    while ((n >> (d + 1)) != 0) d++;
    return d;
  endfunction

  function automatic int unsigned blk_size(input int unsigned n);
    return MEM_SIZE >> tree_depth(n);
  endfunction

  function automatic int unsigned blk_offset(input int unsigned n);
    int unsigned d;
    d = tree_depth(n);
    return (n - (1 << d)) * (MEM_SIZE >> d);
  endfunction

  // preorder successor with the subtree of n left out, zero at the end of the walk
  function automatic int unsigned skip_subtree(input int unsigned n);
    int unsigned m;
    m = n;
    while (m > 1 && (m % 2) == 1) m = m >> 1;
    return (m <= 1) ? 0 : m + 1;
  endfunction

  // depth-first search for the first free block that fits, splitting on the way down
  function automatic logic tree_alloc(input int unsigned want, input logic [LABEL_W-1:0] owner,
                                      output int unsigned at);
    int unsigned n;
    int unsigned sz;
    n  = 1;
    at = 0;
    while (n != 0) begin
      if (blk_state[n] == ST_DIVIDED) begin
        n = 2 * n;
        continue;
      end
      if (blk_state[n] == ST_FREE) begin
        sz = blk_size(n);
        if (sz >= want) begin
          if ((sz / 2) >= want && (sz / 2) >= MIN_BLOCK) begin
            blk_state[n]         = ST_DIVIDED;
            blk_state[2 * n]     = ST_FREE;
            blk_state[2 * n + 1] = ST_FREE;
            n = 2 * n;
            continue;
          end
          blk_state[n] = ST_ALLOC;
          blk_owner[n] = owner;
          at = blk_offset(n);
          return 1'b1;
        end
      end
      n = skip_subtree(n);
    end
    return 1'b0;
  endfunction

  // breadth-first search for the first block held by owner, then merge buddies upward
  function automatic logic tree_free(input logic [LABEL_W-1:0] owner, output int unsigned at);
    int unsigned p;
    at = 0;
    for (int unsigned n = 1; n <= NODE_CNT; n++) begin
      if (blk_state[n] == ST_ALLOC && blk_owner[n] == owner) begin
        blk_state[n] = ST_FREE;
        p = n >> 1;
        while (p >= 1 && blk_state[p] == ST_DIVIDED &&
               blk_state[2 * p] == ST_FREE && blk_state[2 * p + 1] == ST_FREE) begin
          blk_state[p]         = ST_FREE;
          blk_state[2 * p]     = ST_UNUSED;
          blk_state[2 * p + 1] = ST_UNUSED;
          p = p >> 1;
        end
        at = blk_offset(n);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // watch both channels: compare results against the oldest grant, predict each request
  always @(posedge clk_i or negedge rst_ni) begin : track
    grant_t      due;
    int unsigned at;
    logic        done;
    if (!rst_ni) begin
      for (int unsigned n = 1; n <= NODE_CNT; n++) begin
        blk_state[n] = ST_UNUSED;
        blk_owner[n] = '0;
      end
      blk_state[1] = ST_FREE;
      grants_due.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // result side
      if (rsp_chan.valid && rsp_chan.ready) begin
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result ok=%0b offset=%0d with no request outstanding",
                     $realtime, rsp_chan.ok, rsp_chan.block_offset);
          end
        end else begin
          due = grants_due.pop_front();
          if (rsp_chan.ok !== due.ok || rsp_chan.block_offset !== due.offset) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: result mismatch: expected ok=%0b offset=%0d, got ok=%0b offset=%0d",
                       $realtime, due.ok, due.offset, rsp_chan.ok, rsp_chan.block_offset);
            end
          end
        end
      end
      // request side
      if (req_chan.valid && req_chan.ready) begin
        if (req_chan.mode == MODE_ALLOC) begin
          done = tree_alloc(int'(req_chan.request_size), req_chan.label, at);
        end else begin
          done = tree_free(req_chan.label, at);
        end
        due.ok     = done;
        due.offset = done ? OFF_W'(at) : '0;
        grants_due.insert(grants_due.size(), due);
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= grants_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/buddy_block_allocator_tb.sv =====
// testbench top of the buddy block allocator: clock, reset, request stimulus and verdict
`default_nettype none

module buddy_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned RAND_ITEMS  = 1200;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYC  = 400;

  logic        clk_i;
  logic        rst_ni;
  bit          calm = 1'b0;
  int unsigned mismatch_cnt;
  int unsigned grants_pending;

  bba_req_if req_chan ();
  bba_rsp_if rsp_chan ();

  buddy_block_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_chan(req_chan),
    .rsp_chan(rsp_chan)
  );

  bba_grant_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_chan      (req_chan),
    .rsp_chan      (rsp_chan),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (grants_pending)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin : result_pacing
    rsp_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // end the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("buddy_block_allocator_tb: FAIL");
        $finish;
      end
    end
  end

  // offer one request after a random gap and hold it until taken
  task automatic send_req(input logic mode, input int unsigned size,
                          input logic [LABEL_W-1:0] lab);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_chan.valid        <= 1'b1;
    req_chan.mode         <= mode;
    req_chan.request_size <= REQ_W'(size);
    req_chan.label        <= lab;
    @(posedge clk_i);
    while (!req_chan.ready) @(posedge clk_i);
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    req_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (grants_pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [LABEL_W-1:0] held [$];
    logic [LABEL_W-1:0] lab;
    int unsigned        roll;
    int unsigned        pick;
    int unsigned        size;

    req_chan.valid        <= 1'b0;
    req_chan.mode         <= MODE_ALLOC;
    req_chan.request_size <= '0;
    req_chan.label        <= '0;
    rst_ni                <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-byte request gets one minimum block, freeing it merges back to the root
    send_req(MODE_ALLOC, 0, 8'd1);
    send_req(MODE_FREE, 0, 8'd1);
    // whole region, then nothing left, then root freed with no parent to merge
    send_req(MODE_ALLOC, 1024, 8'd2);
    send_req(MODE_ALLOC, 1, 8'd3);
    send_req(MODE_FREE, 2047, 8'd2);
    send_req(MODE_FREE, 0, 8'd2);
    // minimum blocks, a duplicate label, and a request too big for any free block
    send_req(MODE_ALLOC, 16, 8'd0);
    send_req(MODE_ALLOC, 17, 8'd255);
    send_req(MODE_ALLOC, 16, 8'd0);
    send_req(MODE_ALLOC, 513, 8'd7);
    send_req(MODE_ALLOC, 512, 8'd8);
    send_req(MODE_FREE, 0, 8'd0);
    send_req(MODE_FREE, 0, 8'd0);
    send_req(MODE_FREE, 0, 8'd255);
    send_req(MODE_FREE, 0, 8'd8);
    send_req(MODE_ALLOC, 1000, 8'd9);
    send_req(MODE_FREE, 0, 8'd9);
    send_req(MODE_ALLOC, 300, 8'h55);
    send_req(MODE_ALLOC, 300, 8'hAA);
    send_req(MODE_FREE, 0, 8'hAA);
    send_req(MODE_FREE, 0, 8'h55);
    wait_drained();

    // random traffic: mostly alloc/free pairs on live labels, some noise
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 500 && i < 750);
      if (i % 400 == 399) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // free of an arbitrary label, usually no match
        send_req(MODE_FREE, $urandom_range(0, 2047), 8'($urandom_range(0, 255)));
      end else if (held.size() > 0 && roll < ((held.size() > 12) ? 65 : 40)) begin
        pick = $urandom_range(0, held.size() - 1);
        lab  = held[pick];
        held.delete(pick);
        send_req(MODE_FREE, $urandom_range(0, 2047), lab);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 50) size = $urandom_range(0, 32);
        else if (roll < 80) size = $urandom_range(33, 128);
        else if (roll < 94) size = $urandom_range(129, 512);
        else size = $urandom_range(513, 1024);
        if (held.size() > 0 && $urandom_range(0, 9) == 0) begin
          lab = held[$urandom_range(0, held.size() - 1)];
        end else begin
          lab = 8'($urandom_range(0, 255));
        end
        held.insert(held.size(), lab);
        send_req(MODE_ALLOC, size, lab);
      end
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0 && grants_pending == 0) begin
      $display("buddy_block_allocator_tb: PASS");
    end else begin
      $display("buddy_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== buddy_block_allocator.f =====
src/bba_pkg.sv
src/bba_ifs.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/bba_dp.sv
src/buddy_block_allocator.sv
src/bba_checker.sv
sim/bba_grant_checker.sv
sim/buddy_block_allocator_tb.sv
